/* hw/rtl/grce_pkg.sv */
// Shared types and constants for the grid rectangle cell enumerator.
`default_nettype none

package grce_pkg;

  localparam int unsigned COORD_W = 16;  // input coordinates and grid origin
  localparam int unsigned CS_W    = 13;  // cell size
  localparam int unsigned CPR_W   = 4;   // cells per row register
  localparam int unsigned EXT_W   = 18;  // signed width that holds origin plus grid span
  localparam int unsigned OFS_W   = 17;  // clamped offset from the grid origin
  localparam int unsigned Q_W     = 4;   // raw quotient of offset by cell size
  localparam int unsigned CELL_W  = 3;   // clamped row or column number
  localparam int unsigned IDX_W   = 6;   // cell index
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ROW = 2'd3;

  // Order of the four divisions: left, right, top, bottom.
  localparam logic [1:0] DIV_LEFT   = 2'd0;
  localparam logic [1:0] DIV_RIGHT  = 2'd1;
  localparam logic [1:0] DIV_TOP    = 2'd2;
  localparam logic [1:0] DIV_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
  } query_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             is_last;
    logic             no_overlap;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_CHECK,
    S_MISS,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/grid_rect_cell_enumerator.sv */
// Top level: enumerates the grid cells that a query rectangle covers.
//
//   channel   direction  handshake                  payload
//   query     in         start & !busy              query_i  (left_x, top_y, right_x, bottom_y)
//   result    out        result_valid_o, 1 cycle    result_o (cell_index, is_last, no_overlap)
//   config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A transaction on the query channel yields one result for each of the k covered
// cells (1 to 64), or a single flagged result on a miss. One shared divider takes
// the four offsets in turn, each through launch, four quotient bits and hand-back,
// then the covered cells go out in row order, one result per cycle.
// busy stays high until the cycle after the last result; results go out on a
// one-cycle strobe that the receiver cannot stall. Reset clears the sequencer
// and loads the register defaults: origin 0, cell size 16, eight cells a row.
`default_nettype none

module grid_rect_cell_enumerator #(
  parameter int unsigned MAX_CELLS_PER_ROW = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire grce_pkg::query_t               query_i,
  output logic                                busy,
  output logic                                result_valid_o,
  output grce_pkg::result_t                   result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [grce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [grce_pkg::COORD_W-1:0]   cfg_wdata_i
);
  import grce_pkg::*;

  localparam logic [CPR_W-1:0] MAX_N = CPR_W'(MAX_CELLS_PER_ROW);

  // Configuration registers.
  logic signed [COORD_W-1:0] origin_x_q;
  logic signed [COORD_W-1:0] origin_y_q;
  logic [CS_W-1:0]           cell_size_q;
  logic [CPR_W-1:0]          cells_row_q;

  // Sequencer and datapath.
  state_e                    state_q, state_d;
  query_t                    query_q;
  logic [CPR_W-1:0]          n_q;
  logic [CS_W-1:0]           cs_q;
  logic signed [EXT_W-1:0]   max_x_q, max_y_q;
  logic [3:0][OFS_W-1:0]     ofs_q;
  logic [3:0][CELL_W-1:0]    cell_q;
  logic [1:0]                sel_q;
  logic                      pend_q;
  logic [CELL_W-1:0]         x_q, y_q;
  logic [IDX_W-1:0]          base_q;

  logic                      accept;
  logic [OFS_W-1:0]          span;
  logic signed [EXT_W-1:0]   min_x, min_y;
  logic signed [EXT_W-1:0]   lx, ty, rx, by;
  logic signed [EXT_W-1:0]   lx_c, ty_c, rx_c, by_c;
  logic                      miss;
  logic                      div_start;
  logic                      div_done;
  logic [Q_W-1:0]            div_quot;
  logic [Q_W-1:0]            n_last;
  logic [CELL_W-1:0]         quot_clamped;
  logic                      row_end;
  logic                      last_cell;

  assign accept = start && (state_q == S_IDLE);

  // Register writes land on any enabled edge; keep them to idle periods.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= CS_W'(16);
      cells_row_q <= CPR_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:  origin_x_q  <= cfg_wdata_i;
        REG_ORIGIN_Y:  origin_y_q  <= cfg_wdata_i;
        REG_CELL_SIZE: cell_size_q <= cfg_wdata_i[CS_W-1:0];
        REG_CELLS_ROW: cells_row_q <= cfg_wdata_i[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid bounds; the far edge belongs to the grid.
  assign span  = OFS_W'(n_q) * OFS_W'(cs_q);
  assign min_x = EXT_W'(origin_x_q);
  assign min_y = EXT_W'(origin_y_q);

  assign lx = EXT_W'(query_q.left_x);
  assign ty = EXT_W'(query_q.top_y);
  assign rx = EXT_W'(query_q.right_x);
  assign by = EXT_W'(query_q.bottom_y);

  // Miss also covers an inverted rectangle.
  assign miss = (rx < min_x) || (by < min_y) || (lx > max_x_q) || (ty > max_y_q) ||
                (lx > rx) || (ty > by);

  // Clamp each corner into the grid.
  assign lx_c = (lx < min_x) ? min_x : ((lx > max_x_q) ? max_x_q : lx);
  assign rx_c = (rx < min_x) ? min_x : ((rx > max_x_q) ? max_x_q : rx);
  assign ty_c = (ty < min_y) ? min_y : ((ty > max_y_q) ? max_y_q : ty);
  assign by_c = (by < min_y) ? min_y : ((by > max_y_q) ? max_y_q : by);

  // Shared divider; the far edge saturates to the last cell.
  assign div_start = (state_q == S_DIV) && pend_q;

  grce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ofs_q[sel_q]),
    .divisor_i  (cs_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign n_last       = Q_W'(n_q) - 1'b1;
  assign quot_clamped = (div_quot > n_last) ? n_last[CELL_W-1:0] : div_quot[CELL_W-1:0];

  assign row_end   = (x_q == cell_q[DIV_RIGHT]);
  assign last_cell = row_end && (y_q == cell_q[DIV_BOTTOM]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_SPAN;
      S_SPAN:  state_d = S_CHECK;
      S_CHECK: state_d = miss ? S_MISS : S_DIV;
      S_MISS:  state_d = S_IDLE;
      S_DIV:   if (div_done && (sel_q == DIV_BOTTOM)) state_d = S_EMIT;
      S_EMIT:  if (last_cell) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy           = (state_q != S_IDLE);
    result_valid_o = 1'b0;
    result_o       = '0;
    unique case (state_q)
      S_MISS: begin
        result_valid_o      = 1'b1;
        result_o.is_last    = 1'b1;
        result_o.no_overlap = 1'b1;
      end
      S_EMIT: begin
        result_valid_o      = 1'b1;
        result_o.cell_index = base_q + IDX_W'(x_q);
        result_o.is_last    = last_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      sel_q  <= DIV_LEFT;
    end else begin
      if (state_q == S_CHECK) begin
        pend_q <= !miss;
        sel_q  <= DIV_LEFT;
      end else if (div_start) begin
        pend_q <= 1'b0;
      end else if (state_q == S_DIV && div_done && sel_q != DIV_BOTTOM) begin
        pend_q <= 1'b1;
        sel_q  <= sel_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= query_i;
      // Zero cell size acts as one; row count saturates to [1, MAX].
      cs_q    <= (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
      if (cells_row_q == '0) begin
        n_q <= CPR_W'(1);
      end else if (cells_row_q > MAX_N) begin
        n_q <= MAX_N;
      end else begin
        n_q <= cells_row_q;
      end
    end

    if (state_q == S_SPAN) begin
      max_x_q <= min_x + EXT_W'(span);
      max_y_q <= min_y + EXT_W'(span);
    end

    if (state_q == S_CHECK) begin
      ofs_q[DIV_LEFT]   <= OFS_W'(lx_c - min_x);
      ofs_q[DIV_RIGHT]  <= OFS_W'(rx_c - min_x);
      ofs_q[DIV_TOP]    <= OFS_W'(ty_c - min_y);
      ofs_q[DIV_BOTTOM] <= OFS_W'(by_c - min_y);
    end

    if (state_q == S_DIV && div_done) begin
      cell_q[sel_q] <= quot_clamped;
      // Top row is already in place when the last division returns.
      if (sel_q == DIV_BOTTOM) begin
        x_q    <= cell_q[DIV_LEFT];
        y_q    <= cell_q[DIV_TOP];
        base_q <= IDX_W'(cell_q[DIV_TOP]) * IDX_W'(n_q);
      end
    end

    // Advance left to right, then wrap to the next row.
    if (state_q == S_EMIT) begin
      if (row_end) begin
        x_q    <= cell_q[DIV_LEFT];
        y_q    <= y_q + 1'b1;
        base_q <= base_q + IDX_W'(n_q);
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/grce_div.sv */
// Restoring divider of a grid offset by the cell size, one quotient bit per cycle.
`default_nettype none

module grce_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [grce_pkg::OFS_W-1:0] dividend_i,
  input  wire logic [grce_pkg::CS_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [grce_pkg::Q_W-1:0]       quot_o
);
  import grce_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OFS_W-1:0] rem_q;
  logic [Q_W-1:0]   quot_q;
  logic [CS_W-1:0]  dvs_q;

  logic [CNT_W-1:0] shift;
  logic [OFS_W-1:0] trial;
  logic             fits;

  // Quotient never exceeds the row count, so Q_W bits cover it.
  assign shift = LAST_STEP - cnt_q;
  assign trial = OFS_W'(dvs_q) << shift;
  assign fits  = rem_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == LAST_STEP);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
      end
      quot_q <= {quot_q[Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* tb/tb_grid_rect_cell_enumerator.sv */
// Testbench for grid_rect_cell_enumerator: random and directed queries checked against a predictor.

module tb_grid_rect_cell_enumerator;
  import grce_pkg::*;

  localparam int unsigned GRID_MAX      = 8;
  localparam int          SETTLE_CYCLES = 4;          // idle cycles before a register write or drain point
  localparam int          TAIL_CYCLES   = 120;        // covers the longest query
  localparam int          TIMEOUT       = 2_000_000;  // time units, several times the slowest run
  localparam int          REPORT_MAX    = 10;

  // Kinds of work that the stimulus queue holds.
  typedef enum logic [1:0] {
    ACT_QUERY,  // one query transaction
    ACT_WRITE,  // one register write, issued only once the block is idle
    ACT_DRAIN   // hold off until every expected result has come
  } stim_kind_e;

  typedef struct {
    stim_kind_e             kind;
    query_t                 q;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COORD_W-1:0]     data;
  } stim_t;

  // Clock, reset and block inputs start at known values.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  query_t               query_i     = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COORD_W-1:0]   cfg_wdata_i = '0;

  logic                 busy;
  logic                 result_valid_o;
  result_t              result_o;

  stim_t   work_q[$];            // pending queries, writes and drain points
  result_t expected_cells_q[$];  // cell results still owed by the block

  // Register copy as the block holds it, updated when a write is issued.
  logic [COORD_W-1:0] cfg_origin_x  = '0;
  logic [COORD_W-1:0] cfg_origin_y  = '0;
  logic [CS_W-1:0]    cfg_cell_size = 13'd16;
  logic [CPR_W-1:0]   cfg_cells_row = 4'd8;

  // Register copy as the stimulus generator plans it.
  logic [COORD_W-1:0] plan_origin_x  = '0;
  logic [COORD_W-1:0] plan_origin_y  = '0;
  logic [CS_W-1:0]    plan_cell_size = 13'd16;
  logic [CPR_W-1:0]   plan_cells_row = 4'd8;

  int n_fail     = 0;
  int n_accepted = 0;
  int gap_left   = 0;
  int settle_cnt = 0;

  grid_rect_cell_enumerator #(
    .MAX_CELLS_PER_ROW(GRID_MAX)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .query_i       (query_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers shared by the predictor and the generator
  // ---------------------------------------------------------------------------

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // A cell size of zero behaves as one.
  function automatic int cell_span(input logic [CS_W-1:0] cs);
    return (cs == '0) ? 1 : int'(cs);
  endfunction

  // Saturate the row count into 1 .. GRID_MAX.
  function automatic int grid_side(input logic [CPR_W-1:0] n);
    if (n == '0) return 1;
    if (int'(n) > GRID_MAX) return GRID_MAX;
    return int'(n);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: expand one accepted query into the cell results it must cause
  // ---------------------------------------------------------------------------
  task automatic enumerate_cells(input query_t q);
    int      lx, ty, rx, by, cs, n, minx, miny, maxx, maxy;
    int      sx, sy, ex, ey, x, y;
    result_t r;
    lx   = $signed(q.left_x);
    ty   = $signed(q.top_y);
    rx   = $signed(q.right_x);
    by   = $signed(q.bottom_y);
    cs   = cell_span(cfg_cell_size);
    n    = grid_side(cfg_cells_row);
    minx = $signed(cfg_origin_x);
    miny = $signed(cfg_origin_y);
    maxx = minx + n * cs;
    maxy = miny + n * cs;
    // Miss on any side, or an inverted rectangle: one flagged result.
    if (rx < minx || by < miny || lx > maxx || ty > maxy || lx > rx || ty > by) begin
      r.cell_index = '0;
      r.is_last    = 1'b1;
      r.no_overlap = 1'b1;
      expected_cells_q.push_back(r);
      return;
    end
    // Clamp to the grid; the far edge lands in the last row or column.
    sx = clip((clip(lx, minx, maxx) - minx) / cs, 0, n - 1);
    ex = clip((clip(rx, minx, maxx) - minx) / cs, 0, n - 1);
    sy = clip((clip(ty, miny, maxy) - miny) / cs, 0, n - 1);
    ey = clip((clip(by, miny, maxy) - miny) / cs, 0, n - 1);
    for (y = sy; y <= ey; y++) begin
      for (x = sx; x <= ex; x++) begin
        r.cell_index = IDX_W'(y * n + x);
        r.is_last    = (y == ey && x == ex);
        r.no_overlap = 1'b0;
        expected_cells_q.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic add_query(input int lx, input int ty, input int rx, input int by);
    stim_t s;
    s.kind       = ACT_QUERY;
    s.q.left_x   = lx[COORD_W-1:0];
    s.q.top_y    = ty[COORD_W-1:0];
    s.q.right_x  = rx[COORD_W-1:0];
    s.q.bottom_y = by[COORD_W-1:0];
    s.idx        = '0;
    s.data       = '0;
    work_q.push_back(s);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    stim_t s;
    s.kind = ACT_WRITE;
    s.q    = '0;
    s.idx  = idx;
    s.data = data;
    work_q.push_back(s);
    case (idx)
      REG_ORIGIN_X:  plan_origin_x  = data;
      REG_ORIGIN_Y:  plan_origin_y  = data;
      REG_CELL_SIZE: plan_cell_size = data[CS_W-1:0];
      REG_CELLS_ROW: plan_cells_row = data[CPR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_drain();
    stim_t s;
    s.kind = ACT_DRAIN;
    s.q    = '0;
    s.idx  = '0;
    s.data = '0;
    work_q.push_back(s);
  endtask

  function automatic int rand_coord();
    logic signed [COORD_W-1:0] r;
    r = COORD_W'($urandom);
    return r;
  endfunction

  // Pick a coordinate around the grid: inside, next to a cell boundary,
  // in a range that reaches a quarter span past each edge, or exactly on an edge.
  function automatic int near_grid(input int org, input int span, input int cs);
    int v;
    case ($urandom_range(3))
      0:       v = org + int'($urandom_range(span));
      1:       v = org + int'($urandom_range(span / cs)) * cs + int'($urandom_range(2)) - 1;
      2:       v = org - span / 4 + int'($urandom_range(span + span / 2));
      default: v = ($urandom_range(1) == 0) ? org : org + span;
    endcase
    return clip(v, -32768, 32767);
  endfunction

  // Mostly well-formed rectangles near the planned grid, with some noise
  // and some inverted rectangles mixed in.
  task automatic add_random_query();
    int cs, n, span, a, b, c, d, t, mode;
    cs   = cell_span(plan_cell_size);
    n    = grid_side(plan_cells_row);
    span = cs * n;
    mode = $urandom_range(99);
    if (mode < 12) begin
      a = rand_coord();
      b = rand_coord();
      c = rand_coord();
      d = rand_coord();
    end else begin
      a = near_grid($signed(plan_origin_x), span, cs);
      b = near_grid($signed(plan_origin_x), span, cs);
      c = near_grid($signed(plan_origin_y), span, cs);
      d = near_grid($signed(plan_origin_y), span, cs);
      if (a > b) begin t = a; a = b; b = t; end
      if (c > d) begin t = c; c = d; d = t; end
      if (mode < 19) begin
        t = a; a = b; b = t;
      end else if (mode < 26) begin
        t = c; c = d; d = t;
      end
    end
    add_query(a, c, b, d);
  endtask

  // Write all four registers, then queue a batch of random queries with occasional drain points.
  task automatic grid_phase(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                            input logic [COORD_W-1:0] cs_data,
                            input logic [COORD_W-1:0] n_data, input int count);
    add_write(REG_ORIGIN_X, ox);
    add_write(REG_ORIGIN_Y, oy);
    add_write(REG_CELL_SIZE, cs_data);
    add_write(REG_CELLS_ROW, n_data);
    repeat (count) begin
      add_random_query();
      if ($urandom_range(49) == 0) add_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one next-value per signal per edge, applied once at the end
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic                 nx_start;
    query_t               nx_query;
    logic                 nx_we;
    logic [CFG_IDX_W-1:0] nx_idx;
    logic [COORD_W-1:0]   nx_data;
    logic                 quiet;
    if (!rst_ni) begin
      start         <= 1'b0;
      query_i       <= '0;
      cfg_we_i      <= 1'b0;
      cfg_idx_i     <= '0;
      cfg_wdata_i   <= '0;
      cfg_origin_x  <= '0;
      cfg_origin_y  <= '0;
      cfg_cell_size <= 13'd16;
      cfg_cells_row <= 4'd8;
      gap_left      = 0;
      settle_cnt    = 0;
    end else begin
      nx_start = start;
      nx_query = query_i;
      nx_we    = 1'b0;
      nx_idx   = cfg_idx_i;
      nx_data  = cfg_wdata_i;
      // Keep a long stretch of queries with no random idle gaps.
      quiet    = (n_accepted >= 180 && n_accepted < 300);

      // A query is accepted on this edge: predict its results and advance.
      if (start && !busy) begin
        enumerate_cells(query_i);
        void'(work_q.pop_front());
        n_accepted++;
        nx_start = 1'b0;
      end

      // Once start is high it is held until accepted; otherwise pick the next job.
      if (!nx_start) begin
        if (gap_left > 0) begin
          gap_left--;
          nx_query = query_t'({$urandom, $urandom});
        end else if (work_q.size() > 0) begin
          case (work_q[0].kind)
            ACT_QUERY: begin
              if (!quiet && $urandom_range(99) < 9) begin
                // Idle: mostly short gaps, now and then one long enough to
                // land on any phase of the query in flight.
                gap_left = ($urandom_range(7) == 0) ? int'($urandom_range(100, 1)) - 1
                                                    : int'($urandom_range(3, 1)) - 1;
                nx_query = query_t'({$urandom, $urandom});
              end else begin
                nx_start = 1'b1;
                nx_query = work_q[0].q;
              end
            end
            default: begin
              // Writes and drain points wait for a quiet block.
              if (expected_cells_q.size() == 0 && !busy) begin
                if (settle_cnt < SETTLE_CYCLES) begin
                  settle_cnt++;
                end else begin
                  settle_cnt = 0;
                  if (work_q[0].kind == ACT_WRITE) begin
                    nx_we   = 1'b1;
                    nx_idx  = work_q[0].idx;
                    nx_data = work_q[0].data;
                    case (work_q[0].idx)
                      REG_ORIGIN_X:  cfg_origin_x  <= work_q[0].data;
                      REG_ORIGIN_Y:  cfg_origin_y  <= work_q[0].data;
                      REG_CELL_SIZE: cfg_cell_size <= work_q[0].data[CS_W-1:0];
                      REG_CELLS_ROW: cfg_cells_row <= work_q[0].data[CPR_W-1:0];
                      default: ;
                    endcase
                  end
                  void'(work_q.pop_front());
                end
              end else begin
                settle_cnt = 0;
              end
            end
          endcase
        end
      end

      start       <= nx_start;
      query_i     <= nx_query;
      cfg_we_i    <= nx_we;
      cfg_idx_i   <= nx_idx;
      cfg_wdata_i <= nx_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_cells_q.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_MAX)
          $display("unexpected result: index %0d last %0b miss %0b",
                   result_o.cell_index, result_o.is_last, result_o.no_overlap);
      end else begin
        want = expected_cells_q.pop_front();
        if (result_o.cell_index !== want.cell_index || result_o.is_last !== want.is_last ||
            result_o.no_overlap !== want.no_overlap) begin
          n_fail++;
          if (n_fail <= REPORT_MAX)
            $display("mismatch: expected index %0d last %0b miss %0b, got index %0d last %0b miss %0b",
                     want.cell_index, want.is_last, want.no_overlap,
                     result_o.cell_index, result_o.is_last, result_o.no_overlap);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin : plan_proc
    int k;
    // Directed queries on the reset grid: origin 0, cell 16, eight a row (0 .. 128).
    add_query(0, 0, 128, 128);                       // whole grid
    add_query(0, 0, 0, 0);                           // one cell at the origin
    add_query(128, 128, 128, 128);                   // far corner maps to the last cell
    add_query(-32768, -32768, 32767, 32767);         // clamped on every side
    add_query(16, 16, 31, 31);                       // exactly one interior cell
    add_query(15, 15, 16, 16);                       // straddles four cells
    add_query(-5, -5, -1, 200);                      // miss on the left
    add_query(-5, -5, 200, -1);                      // miss above
    add_query(129, 0, 200, 50);                      // miss on the right
    add_query(0, 129, 50, 200);                      // miss below
    add_query(40, 0, 20, 50);                        // inverted in x
    add_query(0, 40, 50, 20);                        // inverted in y
    add_query(32767, 32767, 32767, 32767);           // top extreme
    add_query(-32768, -32768, -32768, -32768);       // bottom extreme
    add_query(127, 0, 128, 0);                       // last column, far edge
    add_query(0, 127, 0, 200);                       // last row, clamped
    add_query(50, 60, 50, 60);                       // single point inside
    add_query(-1, -1, 0, 0);                         // touches the origin corner
    add_drain();                                     // hold off until all results are in

    // Register settings, extremes first, then random ones.
    grid_phase(16'h0000, 16'h0000, 16'd16, 16'd8, 70);
    grid_phase(16'h8000, 16'h8000, 16'd4096, 16'd8, 40);
    grid_phase(16'h7fff, 16'h7fff, 16'd1, 16'd1, 30);
    grid_phase(16'($urandom), 16'($urandom), 16'd0, 16'd0, 30);     // zero size and count
    grid_phase(16'h8000, 16'($urandom), 16'h1fff, 16'h000f, 30);    // widest cells, count over max
    grid_phase(16'hff9c, 16'd50, 16'd7, 16'd9, 30);
    for (k = 0; k < 4; k++)
      grid_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 40);
    grid_phase(16'(int'($urandom_range(400)) - 200), 16'(int'($urandom_range(400)) - 200),
               16'($urandom_range(32, 1)), 16'($urandom_range(8, 1)), 60);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all work to be taken and every result to come back.
    while (work_q.size() != 0 || expected_cells_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_fail == 0 && expected_cells_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog_proc
    #TIMEOUT;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* grid_rect_cell_enumerator.f */
hw/rtl/grce_pkg.sv
hw/rtl/grce_div.sv
hw/rtl/grid_rect_cell_enumerator.sv
tb/tb_grid_rect_cell_enumerator.sv
